FILE: design/mpct_pkg.sv
package mpct_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 13;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  // Reset values of the extents and the cursor
  localparam logic [CFG_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1280;
  localparam logic [CFG_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd720;
  localparam logic [15:0]              POS_X_RESET         = 16'd640;
  localparam logic [15:0]              POS_Y_RESET         = 16'd360;

  // Bit positions within the flags byte
  localparam int unsigned LEFT_BIT   = 0;
  localparam int unsigned RIGHT_BIT  = 1;
  localparam int unsigned MIDDLE_BIT = 2;
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned XSIGN_BIT  = 4;
  localparam int unsigned YSIGN_BIT  = 5;

  // Position of the next byte within a packet
  typedef enum logic [2:0] {
    PH_FLAGS = 3'b001,
    PH_XBYTE = 3'b010,
    PH_YBYTE = 3'b100
  } phase_t;

endpackage

FILE: design/mouse_packet_cursor_tracker.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------
// in_       | input     | in_valid/in_stall  | in_mouse_byte
// out_      | output    | out_valid/out_stall| out_cursor_x/y, out_delta_x/y, buttons
// cfg_      | input     | cfg_we             | cfg_index, cfg_wdata
//
// One byte can be accepted every cycle unless in_stall holds it; the result of a packet
// appears in the output register in the cycle after its third byte is accepted.
// Reset (synchronous, rst_n low) returns to the flags byte phase, restores the default
// extents and centres the cursor at (640, 360).
// A waiting result stalls only the third byte of the next packet; flags and X bytes
// are still taken while the output register is held.
module mouse_packet_cursor_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_mouse_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [COORD_BITS-1:0]               out_cursor_x,
  output logic [COORD_BITS-1:0]               out_cursor_y,
  output logic signed [8:0]                   out_delta_x,
  output logic signed [8:0]                   out_delta_y,
  output logic                                out_left_pressed,
  output logic                                out_right_pressed,
  output logic                                out_middle_pressed,
  input  logic                                cfg_we,
  input  logic [mpct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mpct_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  // Working width for the signed position arithmetic and extent compares
  localparam int unsigned EW = (COORD_BITS + 2 > mpct_pkg::CFG_DATA_BITS + 1) ?
                               COORD_BITS + 2 : mpct_pkg::CFG_DATA_BITS + 1;
  localparam logic [EW-1:0] MAX_EXTENT = EW'(1) << COORD_BITS;

  logic [mpct_pkg::CFG_DATA_BITS-1:0] width_r;
  logic [mpct_pkg::CFG_DATA_BITS-1:0] height_r;
  mpct_pkg::phase_t                   phase_r;
  mpct_pkg::phase_t                   phase_nxt;
  logic [7:0]                         flags_r;
  logic [7:0]                         xbyte_r;
  logic [COORD_BITS-1:0]              pos_x_r;
  logic [COORD_BITS-1:0]              pos_y_r;
  logic [COORD_BITS-1:0]              pos_x_nxt;
  logic [COORD_BITS-1:0]              pos_y_nxt;
  logic                               out_valid_r;
  logic [COORD_BITS-1:0]              cursor_x_r;
  logic [COORD_BITS-1:0]              cursor_y_r;
  logic signed [8:0]                  delta_x_r;
  logic signed [8:0]                  delta_y_r;
  logic [2:0]                         buttons_r;

  logic                               in_accept;
  logic                               packet_done;
  logic signed [8:0]                  dx;
  logic signed [8:0]                  dy;
  logic [EW-1:0]                      ext_x;
  logic [EW-1:0]                      ext_y;
  logic signed [EW-1:0]               sum_x;
  logic signed [EW-1:0]               sum_y;

  // Effective extent: zero acts as one, anything beyond the coordinate range saturates
  function automatic logic [EW-1:0] eff_extent(input logic [mpct_pkg::CFG_DATA_BITS-1:0] r);
    logic [EW-1:0] e;
    e = EW'(r);
    if (e == '0) begin
      e = EW'(1);
    end else if (e > MAX_EXTENT) begin
      e = MAX_EXTENT;
    end
    return e;
  endfunction

  // Clamp a signed coordinate into 0 .. extent-1
  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [EW-1:0] v,
                                                        input logic [EW-1:0] ext);
    logic [EW-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if ($unsigned(v) >= ext) begin
      c = ext - EW'(1);
    end else begin
      c = $unsigned(v);
    end
    return c[COORD_BITS-1:0];
  endfunction

  // Only the byte that completes a packet needs room in the output register
  assign in_stall  = out_valid_r && out_stall && (phase_r == mpct_pkg::PH_YBYTE);
  assign in_accept = in_valid && !in_stall;

  // Phase sequencing; an unknown phase code behaves as the flags phase
  always_comb begin
    phase_nxt   = phase_r;
    packet_done = 1'b0;
    unique case (phase_r)
      mpct_pkg::PH_XBYTE: begin
        phase_nxt = mpct_pkg::PH_YBYTE;
      end
      mpct_pkg::PH_YBYTE: begin
        phase_nxt   = mpct_pkg::PH_FLAGS;
        packet_done = 1'b1;
      end
      default: begin
        if (in_mouse_byte[mpct_pkg::SYNC_BIT]) begin
          phase_nxt = mpct_pkg::PH_XBYTE;
        end
      end
    endcase
  end

  // Signed deltas and the clamped new position
  always_comb begin
    dx        = {flags_r[mpct_pkg::XSIGN_BIT], xbyte_r};
    dy        = {flags_r[mpct_pkg::YSIGN_BIT], in_mouse_byte};
    ext_x     = eff_extent(width_r);
    ext_y     = eff_extent(height_r);
    sum_x     = $signed(EW'(pos_x_r)) + EW'(dx);
    sum_y     = $signed(EW'(pos_y_r)) - EW'(dy);
    pos_x_nxt = clamp_coord(sum_x, ext_x);
    pos_y_nxt = clamp_coord(sum_y, ext_y);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mpct_pkg::SCREEN_WIDTH_RESET;
      height_r <= mpct_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpct_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        mpct_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Packet assembly state and cursor position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mpct_pkg::PH_FLAGS;
      flags_r <= '0;
      xbyte_r <= '0;
      pos_x_r <= mpct_pkg::POS_X_RESET[COORD_BITS-1:0];
      pos_y_r <= mpct_pkg::POS_Y_RESET[COORD_BITS-1:0];
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      if (phase_r == mpct_pkg::PH_XBYTE) begin
        xbyte_r <= in_mouse_byte;
      end else if (phase_r != mpct_pkg::PH_YBYTE && phase_nxt == mpct_pkg::PH_XBYTE) begin
        flags_r <= in_mouse_byte;
      end
      if (packet_done) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
    end
  end

  // Output register valid: set by a completed packet, cleared once the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && packet_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_accept && packet_done) begin
      cursor_x_r <= pos_x_nxt;
      cursor_y_r <= pos_y_nxt;
      delta_x_r  <= dx;
      delta_y_r  <= dy;
      buttons_r  <= {flags_r[mpct_pkg::MIDDLE_BIT], flags_r[mpct_pkg::RIGHT_BIT],
                     flags_r[mpct_pkg::LEFT_BIT]};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_x       = cursor_x_r;
  assign out_cursor_y       = cursor_y_r;
  assign out_delta_x        = delta_x_r;
  assign out_delta_y        = delta_y_r;
  assign out_left_pressed   = buttons_r[0];
  assign out_right_pressed  = buttons_r[1];
  assign out_middle_pressed = buttons_r[2];

endmodule

FILE: tb/sv/tb_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps

module tb_mouse_packet_cursor_tracker;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int GAP_MAX      = 11;

  // One input transaction waiting to be driven, with its lead-in gap
  typedef struct {
    logic [7:0] data;
    int         gap;
  } mouse_byte_t;

  // Contents of one cursor report
  typedef struct packed {
    logic [11:0]       cursor_x;
    logic [11:0]       cursor_y;
    logic signed [8:0] delta_x;
    logic signed [8:0] delta_y;
    logic              left;
    logic              right;
    logic              middle;
  } cursor_report_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [7:0]                          in_mouse_byte;
  logic                                out_valid;
  logic                                out_stall;
  logic [11:0]                         out_cursor_x;
  logic [11:0]                         out_cursor_y;
  logic signed [8:0]                   out_delta_x;
  logic signed [8:0]                   out_delta_y;
  logic                                out_left_pressed;
  logic                                out_right_pressed;
  logic                                out_middle_pressed;
  logic                                cfg_we;
  logic [mpct_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [mpct_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  mouse_byte_t    mouse_bytes_q[$];
  cursor_report_t cursor_reports_q[$];

  // Tracker state as predicted from the accepted bytes
  mpct_pkg::phase_t                   trk_phase  = mpct_pkg::PH_FLAGS;
  logic [7:0]                         trk_flags  = '0;
  logic [7:0]                         trk_xbyte  = '0;
  int                                 trk_pos_x  = 640;
  int                                 trk_pos_y  = 360;
  logic [mpct_pkg::CFG_DATA_BITS-1:0] trk_width  = mpct_pkg::SCREEN_WIDTH_RESET;
  logic [mpct_pkg::CFG_DATA_BITS-1:0] trk_height = mpct_pkg::SCREEN_HEIGHT_RESET;

  int  in_gap_max    = GAP_MAX;
  int  out_gap_max   = GAP_MAX;
  int  lead_wait     = 0;
  int  out_hold      = 0;
  int  bytes_sent    = 0;
  int  bytes_taken   = 0;
  int  reports_seen  = 0;
  int  bytes_dropped = 0;
  int  settings_used = 1;
  int  errors        = 0;
  int  idle_cycles   = 0;
  bit  byte_accepted = 1'b0;
  bit  report_taken  = 1'b0;

  mouse_packet_cursor_tracker #(
    .COORD_BITS(12)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mouse_byte     (in_mouse_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_x      (out_cursor_x),
    .out_cursor_y      (out_cursor_y),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_left_pressed  (out_left_pressed),
    .out_right_pressed (out_right_pressed),
    .out_middle_pressed(out_middle_pressed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // An extent register of zero behaves as one, and anything past the coordinate range
  // is limited to it.
  function automatic int usable_extent(logic [mpct_pkg::CFG_DATA_BITS-1:0] extent);
    if (extent == '0) return 1;
    if (extent > 13'd4096) return 4096;
    return int'(extent);
  endfunction

  function automatic int clamp_to_extent(int coord, int extent);
    if (coord < 0) return 0;
    if (coord >= extent) return extent - 1;
    return coord;
  endfunction

  // Advance the packet assembler by one byte; a completed packet moves the cursor and
  // queues the report that the block should produce.
  function automatic void track_mouse_byte(logic [7:0] data);
    cursor_report_t report;
    int             dx;
    int             dy;
    case (trk_phase)
      mpct_pkg::PH_XBYTE: begin
        trk_xbyte = data;
        trk_phase = mpct_pkg::PH_YBYTE;
      end
      mpct_pkg::PH_YBYTE: begin
        trk_phase = mpct_pkg::PH_FLAGS;
        dx = trk_flags[mpct_pkg::XSIGN_BIT] ? int'(trk_xbyte) - 256 : int'(trk_xbyte);
        dy = trk_flags[mpct_pkg::YSIGN_BIT] ? int'(data) - 256 : int'(data);
        trk_pos_x = clamp_to_extent(trk_pos_x + dx, usable_extent(trk_width));
        trk_pos_y = clamp_to_extent(trk_pos_y - dy, usable_extent(trk_height));
        report.cursor_x = trk_pos_x[11:0];
        report.cursor_y = trk_pos_y[11:0];
        report.delta_x  = dx[8:0];
        report.delta_y  = dy[8:0];
        report.left     = trk_flags[mpct_pkg::LEFT_BIT];
        report.right    = trk_flags[mpct_pkg::RIGHT_BIT];
        report.middle   = trk_flags[mpct_pkg::MIDDLE_BIT];
        cursor_reports_q.push_back(report);
      end
      default: begin
        // Bytes without the sync bit are discarded while hunting for a flags byte.
        if (data[mpct_pkg::SYNC_BIT]) begin
          trk_flags = data;
          trk_phase = mpct_pkg::PH_XBYTE;
        end else begin
          bytes_dropped++;
        end
      end
    endcase
  endfunction

  // Input driver: launches queued transactions after their gaps and holds each one
  // until the block takes it.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !byte_accepted) begin
        // Still stalled; the payload stays as it is.
      end else if (mouse_bytes_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (lead_wait < mouse_bytes_q[0].gap) begin
        in_valid <= 1'b0;
        lead_wait++;
      end else begin
        in_valid      <= 1'b1;
        in_mouse_byte <= mouse_bytes_q[0].data;
        void'(mouse_bytes_q.pop_front());
        lead_wait = 0;
        bytes_sent++;
      end
    end
  end

  // Result side back-pressure: the stall drawn after each report is played out here.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on every accepted byte, checks every accepted report and keeps
  // the watchdog running.
  always @(posedge clk) begin
    cursor_report_t want;
    cursor_report_t got;
    byte_accepted = rst_n && in_valid && !in_stall;
    report_taken  = rst_n && out_valid && !out_stall;
    if (byte_accepted) begin
      bytes_taken++;
      track_mouse_byte(in_mouse_byte);
    end
    if (report_taken) begin
      reports_seen++;
      out_hold = $urandom_range(out_gap_max, 0);
      got = '{out_cursor_x, out_cursor_y, out_delta_x, out_delta_y,
              out_left_pressed, out_right_pressed, out_middle_pressed};
      if (cursor_reports_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: unexpected cursor report %p", got);
        end
      end else begin
        want = cursor_reports_q.pop_front();
        if (got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
            got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
            got.left !== want.left || got.right !== want.right ||
            got.middle !== want.middle) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: report %0d: expected x=%0d y=%0d dx=%0d dy=%0d l=%b r=%b m=%b",
                     reports_seen, want.cursor_x, want.cursor_y, want.delta_x,
                     want.delta_y, want.left, want.right, want.middle);
            $display("       got                x=%0d y=%0d dx=%0d dy=%0d l=%b r=%b m=%b",
                     got.cursor_x, got.cursor_y, got.delta_x, got.delta_y,
                     got.left, got.right, got.middle);
          end
        end
      end
    end
    if (byte_accepted || report_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d reports outstanding",
                 IDLE_LIMIT, cursor_reports_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] data);
    mouse_byte_t item;
    item.data = data;
    item.gap  = $urandom_range(in_gap_max, 0);
    mouse_bytes_q.push_back(item);
  endtask

  // Waits until every queued byte has been taken and every report has arrived, then
  // lets the block settle.
  task automatic wait_until_idle();
    do begin
      @(negedge clk);
      #1;
    end while (mouse_bytes_q.size() != 0 || bytes_sent != bytes_taken ||
               cursor_reports_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_extent(mpct_pkg::cfg_reg_t index,
                              logic [mpct_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == mpct_pkg::REG_SCREEN_WIDTH) begin
      trk_width = value;
    end else begin
      trk_height = value;
    end
  endtask

  // Mostly complete packets with random content; the rest is noise that knocks the
  // assembler out of step.
  task automatic queue_random_packets(int count);
    int         made;
    logic [7:0] flags;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9, 0) == 0) begin
        flags = 8'($urandom_range(255, 0));
        push_byte(flags);
        if (flags[mpct_pkg::SYNC_BIT]) begin
          made++;
        end
      end else begin
        flags = 8'($urandom_range(255, 0));
        flags[mpct_pkg::SYNC_BIT] = 1'b1;
        push_byte(flags);
        push_byte(8'($urandom_range(255, 0)));
        push_byte(8'($urandom_range(255, 0)));
        made += 3;
      end
    end
  endtask

  // One phase: pause until idle, set both extents, then run random traffic.
  task automatic run_phase(logic [mpct_pkg::CFG_DATA_BITS-1:0] width,
                           logic [mpct_pkg::CFG_DATA_BITS-1:0] height,
                           int in_gap, int out_gap, int count);
    wait_until_idle();
    write_extent(mpct_pkg::REG_SCREEN_WIDTH, width);
    write_extent(mpct_pkg::REG_SCREEN_HEIGHT, height);
    settings_used++;
    in_gap_max  = in_gap;
    out_gap_max = out_gap;
    queue_random_packets(count);
  endtask

  // Stimulus sequence.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mouse_byte = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = mpct_pkg::REG_SCREEN_WIDTH;
    cfg_wdata     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed bytes at the reset extents: out-of-sync bytes, zero movement, the
    // largest and most negative deltas, all buttons and the ignored overflow bits.
    push_byte(8'h00);
    push_byte(8'hF7);
    push_byte(8'h08); push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h0F); push_byte(8'hFF); push_byte(8'hFF);
    push_byte(8'h38); push_byte(8'h00); push_byte(8'h00);
    push_byte(8'hF9); push_byte(8'h01); push_byte(8'h80);
    push_byte(8'h1A); push_byte(8'h80); push_byte(8'h7F);
    push_byte(8'h2C); push_byte(8'h7F); push_byte(8'h01);

    // Extremes of the extents, including zero, oversized and a sudden shrink.
    run_phase(13'd1, 13'd1, 0, 0, 150);
    run_phase(13'd0, 13'd0, GAP_MAX, GAP_MAX, 150);
    run_phase(13'd4096, 13'd4096, 0, GAP_MAX, 200);
    run_phase(13'd8191, 13'd8191, GAP_MAX, 0, 200);
    run_phase(13'd16, 13'd9, GAP_MAX, GAP_MAX, 150);
    run_phase(13'd4097, 13'd5000, GAP_MAX, GAP_MAX, 150);
    run_phase(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)),
              GAP_MAX, GAP_MAX, 200);
    run_phase(13'd640, 13'd480, GAP_MAX, GAP_MAX, 200);
    run_phase(13'd2, 13'd4096, 0, 0, 150);

    wait_until_idle();
    $display("Run covered %0d mouse bytes (%0d dropped out of sync) and %0d cursor reports",
             bytes_taken, bytes_dropped, reports_seen);
    $display("across %0d screen extent settings, zero and oversized extents included",
             settings_used);
    if (errors == 0 && cursor_reports_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
